// ===== sv/cthu_pkg.sv =====
package cthu_pkg;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 5;
    localparam int SIDX_W = 4;
    localparam int CNT_W  = 64;
    localparam int MODE_W = 2;
    localparam int PCT_W  = 23;
    localparam int HALF_W = 32;
    localparam int PROD_W = HALF_W + PCT_W;
    localparam int SLOT_CMP_W = 7;

    localparam logic [PCT_W-1:0] PCT_SCALE = 23'd6553600;

    localparam int WIN_SHORT = 60;
    localparam int WIN_MID   = 300;
    localparam int WIN_LONG  = 900;

    typedef enum logic [CMD_W-1:0] {
        CMD_STAGE,
        CMD_COMMIT_OK,
        CMD_COMMIT_FAIL,
        CMD_QUERY
    } cmd_t;

    typedef enum logic [1:0] {
        QS_OK,
        QS_BAD_ARG,
        QS_NO_CPU,
        QS_FAILED
    } qstat_t;

    typedef enum logic [MODE_W-1:0] {
        WIN_60,
        WIN_300,
        WIN_900,
        WIN_BAD
    } wmode_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_COMMIT,
        FS_MARK,
        FS_WALK,
        FS_RDC,
        FS_RDB,
        FS_ACC,
        FS_MUL0,
        FS_MUL1,
        FS_DIVGO,
        FS_DIV
    } fsm_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SLOT_W-1:0]  cpu_slot;
        logic [SIDX_W-1:0]  state_index;
        logic [CNT_W-1:0]   counter_value;
        wmode_t             window_mode;
    } in_word_t;

    typedef struct packed {
        qstat_t             query_status;
        logic [PCT_W-1:0]   percent_q16;
    } out_word_t;

endpackage

// ===== sv/cthu_div.sv =====
module cthu_div
    import cthu_pkg::*;
#(
    parameter int NW = 87,
    parameter int DW = 68,
    parameter int QW = 23
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int KW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [QW-1:0] q_reg, q_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            num_next = num;
            den_next = den;
            q_next   = '0;
            cnt_next = KW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            num_next = {num_reg[NW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == KW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== sv/cpu_time_history_utilization.sv =====
// Channel   Direction  Ports                         Handshake
// command   in         start, item, busy             taken when start and not busy
// result    out        result_strobe, result         one cycle, cannot be held off
// config    in         cfg_we, cfg_data              written when cfg_we is high
//
// Stage, failed commit and a query with a bad argument, a missing cpu or an empty ring
// are handled in the idle state; a query whose latest sample failed answers from the mark state.
// An ok commit stays in the commit state for one history memory write per state.
// A full query makes up to W mark reads to skip failed samples, reads both samples and
// accumulates for each state on the single history port, then runs the 87-step divider.
// Reset clears the ring pointers and staged counters and sets cpus_in_use to 16.
// There is no clearing pass.
// The result strobe cannot be stalled; busy holds off new words while a job runs.
module cpu_time_history_utilization
    import cthu_pkg::*;
#(
    parameter int HISTORY_DEPTH = 1024,
    parameter int STATE_COUNT   = 10,
    parameter int CPU_SLOTS     = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  in_word_t          item,
    output logic              result_strobe,
    output out_word_t         result,
    input  logic              cfg_we,
    input  logic [SLOT_W-1:0] cfg_data
);

    localparam int SLOT_TOTAL = CPU_SLOTS + 1;
    localparam int SW  = $clog2(SLOT_TOTAL);
    localparam int PW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SXW = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int TW  = CNT_W + SXW;
    localparam int MARK_DEPTH = SLOT_TOTAL * HISTORY_DEPTH;
    localparam int MW  = $clog2(MARK_DEPTH);
    localparam int HIST_DEPTH = MARK_DEPTH * STATE_COUNT;
    localparam int AW  = $clog2(HIST_DEPTH);
    localparam int NW  = CNT_W + PCT_W;
    localparam logic [CW:0] HD_X = (CW + 1)'(HISTORY_DEPTH);

    function automatic logic [MW-1:0] mark_addr(input logic [SW-1:0] s, input logic [PW-1:0] p);
        mark_addr = MW'(s) * MW'(HISTORY_DEPTH) + MW'(p);
    endfunction

    function automatic logic [AW-1:0] hist_addr(input logic [SW-1:0] s, input logic [PW-1:0] p,
                                                input logic [SXW-1:0] x);
        hist_addr = AW'(mark_addr(s, p)) * AW'(STATE_COUNT) + AW'(x);
    endfunction

    logic [SLOT_W-1:0] cpus_reg;
    logic [PW-1:0]     first_reg [SLOT_TOTAL];
    logic [CW-1:0]     count_reg [SLOT_TOTAL];
    logic [CNT_W-1:0]  staged_reg [STATE_COUNT];

    fsm_t              fsm_reg, fsm_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [PW-1:0]     curr_reg, curr_next;
    logic [PW-1:0]     base_reg, base_next;
    logic [SXW-1:0]    sel_reg, sel_next;
    logic [SXW-1:0]    sidx_reg, sidx_next;
    logic              single_reg, single_next;
    logic [CNT_W-1:0]  c_reg, c_next;
    logic [CNT_W-1:0]  part_reg, part_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [PROD_W-1:0] prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0] prod_hi_reg, prod_hi_next;
    logic              strobe_reg, strobe_next;
    out_word_t         result_reg, result_next;

    logic              mark_mem [MARK_DEPTH];
    logic              mark_we;
    logic [MW-1:0]     mark_waddr, mark_raddr;
    logic              mark_wdata;
    logic              mark_rdata_reg;
    logic [CNT_W-1:0]  hist_mem [HIST_DEPTH];
    logic              hist_we;
    logic [AW-1:0]     hist_waddr, hist_raddr;
    logic [CNT_W-1:0]  hist_wdata;
    logic [CNT_W-1:0]  hist_rdata_reg;

    logic                  accept;
    logic [SLOT_CMP_W-1:0] in_use;
    logic                  slot_ok;
    logic                  state_ok;
    logic [SW-1:0]         slot_i;
    logic [PW-1:0]         first_i;
    logic [CW-1:0]         cnt_i;
    logic [CW:0]           sum_i;
    logic [CW:0]           sum1_i;
    logic [PW-1:0]         pos_i;
    logic [PW-1:0]         curr_i;
    logic [CW-1:0]         win_i;
    logic [CW-1:0]         back_i;
    logic [PW-1:0]         base_i;
    logic [PW-1:0]         base_inc;
    logic                  last_s;
    logic [CNT_W-1:0]      delta;
    logic [HALF_W-1:0]     mul_a;
    logic [PROD_W-1:0]     mul_p;
    logic                  div_start;
    logic [NW-1:0]         div_num;
    logic                  div_done;
    logic [PCT_W-1:0]      div_q;

    assign accept = start && !busy;
    assign busy   = fsm_reg != FS_IDLE;

    always_comb
    begin
        in_use   = (SLOT_CMP_W'(cpus_reg) < SLOT_CMP_W'(CPU_SLOTS)) ?
                   SLOT_CMP_W'(cpus_reg) : SLOT_CMP_W'(CPU_SLOTS);
        slot_ok  = SLOT_CMP_W'(item.cpu_slot) <= in_use;
        state_ok = {1'b0, item.state_index} < (SIDX_W + 1)'(STATE_COUNT);
        slot_i   = slot_ok ? SW'(item.cpu_slot) : '0;
        first_i  = first_reg[slot_i];
        cnt_i    = count_reg[slot_i];
        sum_i    = (CW + 1)'(first_i) + (CW + 1)'(cnt_i);
        pos_i    = (sum_i >= HD_X) ? PW'(sum_i - HD_X) : PW'(sum_i);
        sum1_i   = sum_i - 1'b1;
        curr_i   = (sum1_i >= HD_X) ? PW'(sum1_i - HD_X) : PW'(sum1_i);
        case (item.window_mode)
            WIN_60:  win_i = CW'(WIN_SHORT);
            WIN_300: win_i = CW'(WIN_MID);
            default: win_i = CW'(WIN_LONG);
        endcase
        back_i   = ((cnt_i - 1'b1) > win_i) ? win_i : (cnt_i - 1'b1);
        base_i   = (CW'(curr_i) >= back_i) ? PW'(CW'(curr_i) - back_i) :
                   PW'((CW + 1)'(curr_i) + HD_X - (CW + 1)'(back_i));
        base_inc = (base_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : base_reg + 1'b1;
        last_s   = sidx_reg == SXW'(STATE_COUNT - 1);
        delta    = single_reg ? c_reg : ((c_reg > hist_rdata_reg) ? c_reg - hist_rdata_reg : '0);
        mul_a    = (fsm_reg == FS_MUL0) ? part_reg[HALF_W-1:0] : part_reg[CNT_W-1:HALF_W];
        mul_p    = PROD_W'(mul_a) * PROD_W'(PCT_SCALE);
        div_num  = NW'(prod_lo_reg) + (NW'(prod_hi_reg) << HALF_W);
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    if ((item.cmd == CMD_COMMIT_OK) && slot_ok)
                        fsm_next = FS_COMMIT;
                    else if ((item.cmd == CMD_QUERY) && state_ok && (item.window_mode != WIN_BAD)
                             && slot_ok && (cnt_i != '0))
                        fsm_next = FS_MARK;
                end
            end
            FS_COMMIT:
            begin
                if (last_s)
                    fsm_next = FS_IDLE;
            end
            FS_MARK:
            begin
                if (!mark_rdata_reg)
                    fsm_next = FS_IDLE;
                else if (single_reg)
                    fsm_next = FS_RDC;
                else
                    fsm_next = FS_WALK;
            end
            FS_WALK:
            begin
                if ((base_reg == curr_reg) || mark_rdata_reg)
                    fsm_next = FS_RDC;
            end
            FS_RDC:  fsm_next = FS_RDB;
            FS_RDB:  fsm_next = FS_ACC;
            FS_ACC:  fsm_next = last_s ? FS_MUL0 : FS_RDC;
            FS_MUL0: fsm_next = FS_MUL1;
            FS_MUL1: fsm_next = FS_DIVGO;
            FS_DIVGO: fsm_next = (total_reg == '0) ? FS_IDLE : FS_DIV;
            FS_DIV:
            begin
                if (div_done)
                    fsm_next = FS_IDLE;
            end
            default: fsm_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        slot_next    = slot_reg;
        curr_next    = curr_reg;
        base_next    = base_reg;
        sel_next     = sel_reg;
        sidx_next    = sidx_reg;
        single_next  = single_reg;
        c_next       = c_reg;
        part_next    = part_reg;
        total_next   = total_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        mark_we      = 1'b0;
        mark_waddr   = mark_addr(slot_i, pos_i);
        mark_wdata   = item.cmd == CMD_COMMIT_OK;
        mark_raddr   = mark_addr(slot_i, curr_i);
        hist_we      = 1'b0;
        hist_waddr   = hist_addr(slot_reg, curr_reg, sidx_reg);
        hist_wdata   = staged_reg[sidx_reg];
        hist_raddr   = hist_addr(slot_reg, curr_reg, sidx_reg);
        div_start    = 1'b0;
        case (fsm_reg)
            FS_IDLE:
            begin
                slot_next   = slot_i;
                sel_next    = SXW'(item.state_index);
                sidx_next   = '0;
                total_next  = '0;
                part_next   = '0;
                single_next = cnt_i == CW'(1);
                base_next   = base_i;
                curr_next   = (item.cmd == CMD_QUERY) ? curr_i : pos_i;
                if (accept)
                begin
                    if (((item.cmd == CMD_COMMIT_OK) || (item.cmd == CMD_COMMIT_FAIL)) && slot_ok)
                        mark_we = 1'b1;
                    if (item.cmd == CMD_QUERY)
                    begin
                        result_next.percent_q16 = '0;
                        if (!state_ok || (item.window_mode == WIN_BAD))
                        begin
                            strobe_next = 1'b1;
                            result_next.query_status = QS_BAD_ARG;
                        end
                        else if (!slot_ok)
                        begin
                            strobe_next = 1'b1;
                            result_next.query_status = QS_NO_CPU;
                        end
                        else if (cnt_i == '0)
                        begin
                            strobe_next = 1'b1;
                            result_next.query_status = QS_OK;
                        end
                    end
                end
            end
            FS_COMMIT:
            begin
                hist_we   = 1'b1;
                sidx_next = sidx_reg + 1'b1;
            end
            FS_MARK:
            begin
                mark_raddr = mark_addr(slot_reg, base_reg);
                if (!mark_rdata_reg)
                begin
                    strobe_next = 1'b1;
                    result_next.query_status = QS_FAILED;
                    result_next.percent_q16 = '0;
                end
            end
            FS_WALK:
            begin
                mark_raddr = mark_addr(slot_reg, base_inc);
                if ((base_reg != curr_reg) && !mark_rdata_reg)
                    base_next = base_inc;
            end
            FS_RDC:
            begin
                hist_raddr = hist_addr(slot_reg, curr_reg, sidx_reg);
            end
            FS_RDB:
            begin
                c_next     = hist_rdata_reg;
                hist_raddr = hist_addr(slot_reg, base_reg, sidx_reg);
            end
            FS_ACC:
            begin
                total_next = total_reg + TW'(delta);
                if (sidx_reg == sel_reg)
                    part_next = delta;
                sidx_next = sidx_reg + 1'b1;
            end
            FS_MUL0: prod_lo_next = mul_p;
            FS_MUL1: prod_hi_next = mul_p;
            FS_DIVGO:
            begin
                if (total_reg == '0)
                begin
                    strobe_next = 1'b1;
                    result_next.query_status = QS_OK;
                    result_next.percent_q16 = '0;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            FS_DIV:
            begin
                if (div_done)
                begin
                    strobe_next = 1'b1;
                    result_next.query_status = QS_OK;
                    result_next.percent_q16 = (div_q > PCT_SCALE) ? PCT_SCALE : div_q;
                end
            end
            default: strobe_next = 1'b0;
        endcase
    end

    cthu_div #(
        .NW (NW),
        .DW (TW),
        .QW (PCT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (total_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        mark_rdata_reg <= mark_mem[mark_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpus_reg   <= SLOT_W'(16);
            fsm_reg    <= FS_IDLE;
            strobe_reg <= 1'b0;
            sidx_reg   <= '0;
            for (int i = 0; i < SLOT_TOTAL; i++)
            begin
                first_reg[i] <= '0;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < STATE_COUNT; i++)
                staged_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cpus_reg <= cfg_data;
            fsm_reg    <= fsm_next;
            strobe_reg <= strobe_next;
            sidx_reg   <= sidx_next;
            if (accept && (item.cmd == CMD_STAGE) && state_ok)
                staged_reg[SXW'(item.state_index)] <= item.counter_value;
            if (accept && ((item.cmd == CMD_COMMIT_OK) || (item.cmd == CMD_COMMIT_FAIL))
                && slot_ok)
            begin
                if (cnt_i < CW'(HISTORY_DEPTH))
                    count_reg[slot_i] <= cnt_i + 1'b1;
                else
                    first_reg[slot_i] <= (first_i == PW'(HISTORY_DEPTH - 1)) ? '0 :
                                         first_i + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        curr_reg    <= curr_next;
        base_reg    <= base_next;
        sel_reg     <= sel_next;
        single_reg  <= single_next;
        c_reg       <= c_next;
        part_reg    <= part_next;
        total_reg   <= total_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        result_reg  <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    a_pct_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.query_status != QS_OK) |-> result.percent_q16 == '0)
        else $error("nonzero percent with error status");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> result.percent_q16 <= PCT_SCALE)
        else $error("percent above full scale");

    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy) || $past(start))
        else $error("result word without a command");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> fsm_reg == FS_DIV)
        else $error("divider finished outside of its wait state");

    a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == FS_COMMIT) || (fsm_reg == FS_ACC) |-> sidx_reg <= SXW'(STATE_COUNT - 1))
        else $error("state sweep index out of range");

endmodule

// ===== tb/tb_cpu_time_history_utilization.sv =====
module tb_cpu_time_history_utilization;
    import cthu_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int NSTATES   = 10;
    localparam int NSLOTS    = 16;
    localparam int IDLE_LIMIT = 5000;

    class util_scoreboard;
        bit [63:0]  staged [NSTATES];
        bit [63:0]  hist_cnt [int];
        bit         hist_ok [int];
        int         first [NSLOTS+1];
        int         count [NSLOTS+1];
        int         cpus;
        out_word_t  pending [$];
        int         errors;

        function void clear();
            foreach (staged[i]) staged[i] = '0;
            foreach (first[i])
            begin
                first[i] = 0;
                count[i] = 0;
            end
            hist_cnt.delete();
            hist_ok.delete();
            cpus = 16;
            errors = 0;
        endfunction

        function int live_slots();
            return (cpus < NSLOTS) ? cpus : NSLOTS;
        endfunction

        function bit [63:0] counter_at(int slot, int pos, int s);
            return hist_cnt[(slot * DEPTH + pos) * NSTATES + s];
        endfunction

        function void push_sample(int slot, bit ok);
            int pos;
            pos = first[slot] + count[slot];
            if (pos >= DEPTH) pos -= DEPTH;
            if (count[slot] < DEPTH) count[slot]++;
            else
            begin
                first[slot]++;
                if (first[slot] >= DEPTH) first[slot] = 0;
            end
            if (ok)
                for (int s = 0; s < NSTATES; s++)
                    hist_cnt[(slot * DEPTH + pos) * NSTATES + s] = staged[s];
            hist_ok[slot * DEPTH + pos] = ok;
        endfunction

        function out_word_t utilization(int slot, int st, wmode_t mode);
            out_word_t  r;
            int         win, cur, base, back;
            bit [127:0] tot, num, q;
            bit [63:0]  part, c, b;
            r.query_status = QS_OK;
            r.percent_q16 = '0;
            tot = '0;
            if (st >= NSTATES || mode == WIN_BAD)
            begin
                r.query_status = QS_BAD_ARG;
                return r;
            end
            win = (mode == WIN_60) ? WIN_SHORT : (mode == WIN_300) ? WIN_MID : WIN_LONG;
            if (slot > live_slots())
            begin
                r.query_status = QS_NO_CPU;
                return r;
            end
            if (count[slot] == 0) return r;
            cur = first[slot] + count[slot] - 1;
            if (cur >= DEPTH) cur -= DEPTH;
            if (!hist_ok[slot * DEPTH + cur])
            begin
                r.query_status = QS_FAILED;
                return r;
            end
            if (count[slot] == 1)
            begin
                for (int s = 0; s < NSTATES; s++) tot += counter_at(slot, cur, s);
                part = counter_at(slot, cur, st);
            end
            else
            begin
                back = count[slot] - 1;
                if (back > win) back = win;
                base = (cur >= back) ? cur - back : cur + DEPTH - back;
                while (base != cur && !hist_ok[slot * DEPTH + base])
                begin
                    base++;
                    if (base >= DEPTH) base = 0;
                end
                for (int s = 0; s < NSTATES; s++)
                begin
                    c = counter_at(slot, cur, s);
                    b = counter_at(slot, base, s);
                    if (c > b) tot += c - b;
                end
                c = counter_at(slot, cur, st);
                b = counter_at(slot, base, st);
                part = (c > b) ? c - b : '0;
            end
            if (tot != 0)
            begin
                num = {64'b0, part} * 128'd6553600;
                q = num / tot;
                if (q > 128'd6553600) q = 128'd6553600;
                r.percent_q16 = q[PCT_W-1:0];
            end
            return r;
        endfunction

        function void note_word(in_word_t w);
            case (w.cmd)
                CMD_STAGE:
                    if (w.state_index < NSTATES) staged[w.state_index] = w.counter_value;
                CMD_COMMIT_OK, CMD_COMMIT_FAIL:
                    if (w.cpu_slot <= live_slots())
                        push_sample(w.cpu_slot, w.cmd == CMD_COMMIT_OK);
                default:
                    pending.push_back(utilization(w.cpu_slot, w.state_index, w.window_mode));
            endcase
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0)
            begin
                $error("unexpected result word status=%0d percent=%0d",
                       got.query_status, got.percent_q16);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.query_status !== exp_w.query_status)
            begin
                $error("query_status expected %0d actual %0d",
                       exp_w.query_status, got.query_status);
                errors++;
            end
            if (got.percent_q16 !== exp_w.percent_q16)
            begin
                $error("percent_q16 expected %0d actual %0d",
                       exp_w.percent_q16, got.percent_q16);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    in_word_t          item = '0;
    logic              result_strobe;
    out_word_t         result;
    logic              cfg_we = 1'b0;
    logic [SLOT_W-1:0] cfg_data = '0;

    util_scoreboard sb = new();
    int idle_cycles = 0;
    int sent = 0;
    bit [63:0] clock_now [NSTATES];

    cpu_time_history_utilization dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_strobe(result_strobe), .result(result),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
                sb.note_word(item);
            if (result_strobe)
                sb.check_word(result);
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send(cmd_t c, int slot, int st, bit [63:0] v, wmode_t m, int gap);
        in_word_t w;
        w.cmd = c;
        w.cpu_slot = slot[SLOT_W-1:0];
        w.state_index = st[SIDX_W-1:0];
        w.counter_value = v;
        w.window_mode = m;
        start <= 1'b1;
        item <= w;
        do @(posedge clk); while (busy);
        sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_rand(cmd_t c, int slot, int st, bit [63:0] v, wmode_t m);
        send(c, slot, st, v, m, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (busy || sb.pending.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cpus(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v[SLOT_W-1:0];
        @(posedge clk);
        sb.cpus = v;
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_slot();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 1;
        if (r < 9) return $urandom_range(0, 17);
        return $urandom_range(0, 31);
    endfunction

    initial
    begin
        sb.clear();
        foreach (clock_now[i]) clock_now[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_QUERY, 5, 0, '0, WIN_60, 0);
        send(CMD_QUERY, 0, 0, '0, WIN_BAD, 0);
        send(CMD_QUERY, 0, 15, '0, WIN_60, 1);
        send(CMD_QUERY, 17, 3, '0, WIN_300, 0);
        send(CMD_QUERY, 31, 3, '0, WIN_900, 2);
        send(CMD_COMMIT_OK, 0, 0, '0, WIN_60, 0);
        send(CMD_QUERY, 0, 0, '0, WIN_60, 0);
        for (int s = 0; s < NSTATES; s++)
            send(CMD_STAGE, 0, s, (s == 9) ? '1 : 64'(s * 1000), WIN_60, 0);
        send(CMD_STAGE, 0, 10, '1, WIN_60, 0);
        send(CMD_STAGE, 31, 15, 64'h5555_aaaa_5555_aaaa, WIN_BAD, 0);
        send(CMD_COMMIT_OK, 2, 0, '0, WIN_60, 0);
        send(CMD_QUERY, 2, 9, '0, WIN_60, 0);
        send(CMD_QUERY, 2, 4, '0, WIN_900, 0);
        send(CMD_COMMIT_OK, 2, 0, '0, WIN_60, 0);
        send(CMD_QUERY, 2, 4, '0, WIN_300, 0);
        send(CMD_COMMIT_FAIL, 2, 0, '0, WIN_60, 0);
        send(CMD_QUERY, 2, 4, '0, WIN_60, 0);
        send(CMD_COMMIT_OK, 20, 0, '0, WIN_60, 0);

        write_cpus(1);
        send(CMD_QUERY, 2, 4, '0, WIN_60, 0);
        send(CMD_COMMIT_OK, 1, 0, '0, WIN_60, 0);
        send(CMD_QUERY, 1, 0, '0, WIN_60, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_cpus(16);
                1: write_cpus($urandom_range(1, 16));
                2: write_cpus(1);
                default: write_cpus(16);
            endcase
            while (sent < 100 * (phase + 1) + 25)
            begin
                int k, n, st;
                k = $urandom_range(0, 9);
                if (k < 4)
                begin
                    send_rand(($urandom_range(0, 4) == 0) ? CMD_COMMIT_FAIL : CMD_COMMIT_OK,
                              pick_slot(), $urandom_range(0, 15), {$urandom, $urandom},
                              wmode_t'($urandom_range(0, 3)));
                end
                else if (k < 6)
                begin
                    n = $urandom_range(1, NSTATES);
                    for (int i = 0; i < n; i++)
                    begin
                        st = $urandom_range(0, NSTATES - 1);
                        if ($urandom_range(0, 15) == 0) clock_now[st] = {$urandom, $urandom};
                        else clock_now[st] += $urandom_range(0, 5000);
                        send_rand(CMD_STAGE, $urandom_range(0, 31), st, clock_now[st],
                                  wmode_t'($urandom_range(0, 3)));
                    end
                end
                else if (k < 9)
                begin
                    send_rand(CMD_QUERY, pick_slot(),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, NSTATES - 1),
                              {$urandom, $urandom},
                              wmode_t'(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)));
                end
                else
                begin
                    send_rand(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                              $urandom_range(0, 15), {$urandom, $urandom},
                              wmode_t'($urandom_range(0, 3)));
                end
            end
        end

        drain();
        repeat (1200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
